FILE: rtl/round_robin_run_queue_pid_alloc_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the round-robin run queue.
// Shared property forms for the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_RUN_QUEUE_PID_ALLOC_ASSERT_SVH
`define ROUND_ROBIN_RUN_QUEUE_PID_ALLOC_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RRQ_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RRQ_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/rrq_pkg.sv
// ----------------------------------------------------------------------------
// rrq_pkg
// Sizes, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package rrq_pkg;

	localparam int NUM_IDS = 256;
	localparam int ID_W    = $clog2(NUM_IDS);
	localparam int CNT_W   = ID_W + 1;

	typedef enum logic [1:0] {
		MODE_TICK  = 2'd0,
		MODE_SPAWN = 2'd1,
		MODE_KILL  = 2'd2,
		MODE_HOLD  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_NO_FREE      = 2'd1,
		ST_NOT_IN_QUEUE = 2'd2
	} status_t;

	typedef struct packed {
		logic tick;
		logic tick_fin;
		logic hold;
		logic spawn_init;
		logic spawn_step;
		logic kill_init;
		logic kill_step;
		logic kill_last;
		logic kill_commit;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic full;
		logic spawn_hit;
		logic spawn_wrap;
		logic kill_hit;
		logic kill_miss;
		logic rsp_free;
	} stat_t;

endpackage

FILE: rtl/rrq_req_if.sv
// ----------------------------------------------------------------------------
// rrq_req_if
// Request channel: operation mode and target id.
// ----------------------------------------------------------------------------
interface rrq_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] mode;
	logic [7:0] target_id;

	modport source (output valid, output mode, output target_id, input ready);
	modport sink (input valid, input mode, input target_id, output ready);
endinterface

FILE: rtl/rrq_rsp_if.sv
// ----------------------------------------------------------------------------
// rrq_rsp_if
// Response channel: id, status and run queue length.
// ----------------------------------------------------------------------------
interface rrq_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] id_out;
	logic [1:0] status;
	logic [8:0] queue_count;

	modport source (output valid, output id_out, output status, output queue_count,
		input ready);
	modport sink (input valid, input id_out, input status, input queue_count,
		output ready);
endinterface

FILE: rtl/round_robin_run_queue_pid_alloc.sv
// ----------------------------------------------------------------------------
// round_robin_run_queue_pid_alloc
// Round-robin run queue with process id allocation.
// ----------------------------------------------------------------------------
// One request beat is taken at a time and answered by one response beat. A
// tick reads the next entry through the registered read port, then moves to
// the response register (straight there when the queue is empty). A spawn
// walks the presence map one id per cycle from the running id upward, and
// goes straight to the response register when the queue is full. A kill
// reads the run queue memory one entry per cycle through its registered read
// port, then reads the last entry and moves it into the freed slot. The
// response register frees the request side as soon as a result is loaded;
// ready stays low while an operation is in flight or a finished result waits
// for the register.
module round_robin_run_queue_pid_alloc (
	input logic        clk,
	input logic        arst_n,
	rrq_req_if.sink    req,
	rrq_rsp_if.source  rsp
);

	rrq_pkg::cmd_t  cmd;
	rrq_pkg::stat_t stat;

	rrq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rrq_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.req_target (req.target_id),
		.rsp        (rsp)
	);

endmodule

FILE: rtl/rrq_ctrl.sv
// ----------------------------------------------------------------------------
// rrq_ctrl
// Operation sequencer: steps the datapath through tick, spawn, kill and hold.
// ----------------------------------------------------------------------------
module rrq_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	input  logic [1:0]    req_mode,
	output logic          req_ready,
	input  rrq_pkg::stat_t stat,
	output rrq_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_TICK_RD,
		S_SPAWN_SCAN,
		S_KILL_SCAN,
		S_KILL_LAST,
		S_KILL_MOVE,
		S_EMIT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					unique case (rrq_pkg::mode_t'(req_mode))
						rrq_pkg::MODE_TICK: begin
							cmd.tick = 1'b1;
							state_d  = stat.len_zero ? S_EMIT : S_TICK_RD;
						end
						rrq_pkg::MODE_SPAWN: begin
							cmd.spawn_init = 1'b1;
							state_d        = stat.full ? S_EMIT : S_SPAWN_SCAN;
						end
						rrq_pkg::MODE_KILL: begin
							cmd.kill_init = 1'b1;
							state_d       = stat.len_zero ? S_EMIT : S_KILL_SCAN;
						end
						rrq_pkg::MODE_HOLD: begin
							cmd.hold = 1'b1;
							state_d  = S_EMIT;
						end
					endcase
				end
			end
			S_TICK_RD: begin
				cmd.tick_fin = 1'b1;
				state_d      = S_EMIT;
			end
			S_SPAWN_SCAN: begin
				cmd.spawn_step = 1'b1;
				if (stat.spawn_hit || stat.spawn_wrap) begin
					state_d = S_EMIT;
				end
			end
			S_KILL_SCAN: begin
				cmd.kill_step = 1'b1;
				if (stat.kill_hit) begin
					state_d = S_KILL_LAST;
				end else if (stat.kill_miss) begin
					state_d = S_EMIT;
				end
			end
			S_KILL_LAST: begin
				cmd.kill_last = 1'b1;
				state_d       = S_KILL_MOVE;
			end
			S_KILL_MOVE: begin
				cmd.kill_commit = 1'b1;
				state_d         = S_EMIT;
			end
			S_EMIT: begin
				if (stat.rsp_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: rtl/rrq_dpath.sv
// ----------------------------------------------------------------------------
// rrq_dpath
// Presence map, run queue memory, queue pointers and the response register.
// ----------------------------------------------------------------------------
module rrq_dpath (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rrq_pkg::cmd_t            cmd,
	output rrq_pkg::stat_t           stat,
	input  logic [rrq_pkg::ID_W-1:0] req_target,
	rrq_rsp_if.source                rsp
);

	logic [rrq_pkg::ID_W-1:0]    rq_mem [rrq_pkg::NUM_IDS];
	logic [rrq_pkg::NUM_IDS-1:0] present_q;
	logic [rrq_pkg::CNT_W-1:0]   len_q;
	logic [rrq_pkg::CNT_W-1:0]   rd_idx_q;
	logic [rrq_pkg::ID_W-1:0]    pos_q;
	logic [rrq_pkg::ID_W-1:0]    run_q;
	logic [rrq_pkg::ID_W-1:0]    scan_q;
	logic [rrq_pkg::ID_W-1:0]    cmp_idx_q;
	logic                        cmp_v_q;
	logic [rrq_pkg::ID_W-1:0]    found_q;
	logic [rrq_pkg::ID_W-1:0]    target_q;
	logic [rrq_pkg::ID_W-1:0]    rdata_q;
	logic [rrq_pkg::ID_W-1:0]    res_id_q;
	rrq_pkg::status_t            res_status_q;
	logic                        rsp_valid_q;
	logic [rrq_pkg::ID_W-1:0]    rsp_id_q;
	rrq_pkg::status_t            rsp_status_q;
	logic [rrq_pkg::CNT_W-1:0]   rsp_count_q;

	logic [rrq_pkg::CNT_W-1:0]   tick_next_wide;
	logic [rrq_pkg::ID_W-1:0]    tick_next;
	logic [rrq_pkg::CNT_W-1:0]   last_wide;
	logic [rrq_pkg::ID_W-1:0]    scan_next;
	logic [rrq_pkg::ID_W-1:0]    rd_addr;
	logic                        wr_en;
	logic [rrq_pkg::ID_W-1:0]    wr_addr;
	logic [rrq_pkg::ID_W-1:0]    wr_data;
	logic                        rd_in_range;

	assign tick_next_wide = {1'b0, pos_q} + rrq_pkg::CNT_W'(1);
	assign tick_next      = (tick_next_wide >= len_q) ? '0 : tick_next_wide[rrq_pkg::ID_W-1:0];
	assign last_wide      = len_q - rrq_pkg::CNT_W'(1);
	assign scan_next      = (scan_q == rrq_pkg::ID_W'(rrq_pkg::NUM_IDS - 1)) ? '0 :
		scan_q + rrq_pkg::ID_W'(1);
	assign rd_in_range    = (rd_idx_q < len_q);

	assign stat.len_zero   = (len_q == '0);
	assign stat.full       = (len_q >= rrq_pkg::CNT_W'(rrq_pkg::NUM_IDS));
	assign stat.spawn_hit  = !present_q[scan_q];
	assign stat.spawn_wrap = present_q[scan_q] && (scan_next == run_q);
	assign stat.kill_hit   = cmp_v_q && (rdata_q == target_q);
	assign stat.kill_miss  = cmp_v_q && (rdata_q != target_q) &&
		({1'b0, cmp_idx_q} == last_wide);
	assign stat.rsp_free   = !rsp_valid_q || rsp.ready;

	always_comb begin
		priority if (cmd.tick) begin
			rd_addr = tick_next;
		end else if (cmd.kill_last) begin
			rd_addr = last_wide[rrq_pkg::ID_W-1:0];
		end else begin
			rd_addr = rd_idx_q[rrq_pkg::ID_W-1:0];
		end
	end

	assign wr_en   = (cmd.spawn_step && stat.spawn_hit) || cmd.kill_commit;
	assign wr_addr = cmd.kill_commit ? found_q : len_q[rrq_pkg::ID_W-1:0];
	assign wr_data = cmd.kill_commit ? rdata_q : scan_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			rq_mem[wr_addr] <= wr_data;
		end
		rdata_q <= rq_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q   <= '0;
			len_q       <= '0;
			pos_q       <= '0;
			run_q       <= '0;
			rd_idx_q    <= '0;
			cmp_v_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.tick) begin
				pos_q <= tick_next;
				if (stat.len_zero) begin
					run_q <= '0;
				end
			end
			if (cmd.tick_fin) begin
				run_q <= rdata_q;
			end
			if (cmd.spawn_step && stat.spawn_hit) begin
				present_q[scan_q] <= 1'b1;
				len_q             <= len_q + rrq_pkg::CNT_W'(1);
			end
			if (cmd.kill_init) begin
				present_q[req_target] <= 1'b0;
				rd_idx_q              <= '0;
				cmp_v_q               <= 1'b0;
			end
			if (cmd.kill_step) begin
				cmp_v_q  <= rd_in_range;
				rd_idx_q <= rd_idx_q + rrq_pkg::CNT_W'(rd_in_range);
			end
			if (cmd.kill_commit) begin
				len_q <= last_wide;
			end
			if (cmd.emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick && stat.len_zero) begin
			res_id_q     <= '0;
			res_status_q <= rrq_pkg::ST_OK;
		end
		if (cmd.tick_fin) begin
			res_id_q     <= rdata_q;
			res_status_q <= rrq_pkg::ST_OK;
		end
		if (cmd.hold) begin
			res_id_q     <= run_q;
			res_status_q <= rrq_pkg::ST_OK;
		end
		if (cmd.spawn_init) begin
			scan_q <= run_q;
			if (stat.full) begin
				res_id_q     <= '0;
				res_status_q <= rrq_pkg::ST_NO_FREE;
			end
		end
		if (cmd.spawn_step) begin
			if (stat.spawn_hit) begin
				res_id_q     <= scan_q;
				res_status_q <= rrq_pkg::ST_OK;
			end else if (stat.spawn_wrap) begin
				res_id_q     <= '0;
				res_status_q <= rrq_pkg::ST_NO_FREE;
			end else begin
				scan_q <= scan_next;
			end
		end
		if (cmd.kill_init) begin
			target_q <= req_target;
			if (stat.len_zero) begin
				res_id_q     <= req_target;
				res_status_q <= rrq_pkg::ST_NOT_IN_QUEUE;
			end
		end
		if (cmd.kill_step) begin
			cmp_idx_q <= rd_idx_q[rrq_pkg::ID_W-1:0];
			if (stat.kill_hit) begin
				found_q <= cmp_idx_q;
			end else if (stat.kill_miss) begin
				res_id_q     <= target_q;
				res_status_q <= rrq_pkg::ST_NOT_IN_QUEUE;
			end
		end
		if (cmd.kill_commit) begin
			res_id_q     <= target_q;
			res_status_q <= rrq_pkg::ST_OK;
		end
		if (cmd.emit) begin
			rsp_id_q     <= res_id_q;
			rsp_status_q <= res_status_q;
			rsp_count_q  <= len_q;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.id_out      = rsp_id_q;
	assign rsp.status      = rsp_status_q;
	assign rsp.queue_count = rsp_count_q;

endmodule

FILE: rtl/rrq_checker.sv
// ----------------------------------------------------------------------------
// rrq_checker
// Port-level checks on the run queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "round_robin_run_queue_pid_alloc_assert.svh"

module rrq_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic [7:0] rsp_id_out,
	input logic [1:0] rsp_status,
	input logic [8:0] rsp_queue_count
);

	`RRQ_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready, "request taken while busy")
	`RRQ_ASSERT_IMP(a_no_free_id_zero, rsp_valid && (rsp_status == rrq_pkg::ST_NO_FREE), rsp_id_out == '0, "failed spawn with nonzero id")
	`RRQ_ASSERT_IMP(a_count_bound, rsp_valid, rsp_queue_count <= 9'(rrq_pkg::NUM_IDS), "queue count above capacity")
	`RRQ_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_id_out) && $stable(rsp_status) && $stable(rsp_queue_count), "response beat changed while stalled")

endmodule

bind round_robin_run_queue_pid_alloc rrq_checker u_rrq_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_id_out      (rsp.id_out),
	.rsp_status      (rsp.status),
	.rsp_queue_count (rsp.queue_count)
);
